// File: src/dpdm_pkg.sv
`default_nettype none

package dpdm_pkg;

  // Default sizes of the span counters and of the debounce counter.
  localparam int unsigned COUNT_BITS_DEF    = 16;
  localparam int unsigned DEBOUNCE_BITS_DEF = 8;

  // Configuration port layout.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned DEB_CFG_W  = 8;
  localparam int unsigned TIMEOUT_W  = 16;
  localparam int unsigned READS_W    = 16;
  localparam int unsigned DUTY_W     = 7;
  localparam int unsigned QUO_W      = 7;

  // Register values after reset.
  localparam int unsigned DEBOUNCE_RESET = 5;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd20000;

  // Duty reported for a stuck low line or a lost edge.
  localparam logic [DUTY_W-1:0] DUTY_FULL = 7'd100;

  // Register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE = 1'b0,
    REG_TIMEOUT  = 1'b1
  } cfg_reg_e;

  // Outcome codes of a result.
  typedef enum logic [1:0] {
    OUT_MEASURED   = 2'd0,
    OUT_STUCK_HIGH = 2'd1,
    OUT_STUCK_LOW  = 2'd2,
    OUT_EDGE_LOST  = 2'd3
  } outcome_e;

  // Controller states: the four waits of a measurement, then the divider.
  typedef enum logic [2:0] {
    ST_WAIT_LOW  = 3'd0,
    ST_WAIT_HIGH = 3'd1,
    ST_HIGH_SPAN = 3'd2,
    ST_LOW_SPAN  = 3'd3,
    ST_DIV_LOAD  = 3'd4,
    ST_DIV_STEP  = 3'd5
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     sample_en;
    logic     expect_high;
    logic     high_cap;
    logic     low_cap;
    logic     div_load;
    logic     div_step;
    logic     res_load;
    outcome_e res_sel;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic done;
    logic val_gt0;
    logic val_gt1;
    logic high_gt0;
    logic div_last;
  } dp_sts_t;

endpackage

`default_nettype wire

// File: src/dpdm_dp.sv
`default_nettype none

module dpdm_dp #(
  parameter int unsigned COUNT_BITS    = dpdm_pkg::COUNT_BITS_DEF,
  parameter int unsigned DEBOUNCE_BITS = dpdm_pkg::DEBOUNCE_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             pin_level_i,
  input  logic                             cfg_valid_i,
  input  logic [dpdm_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [dpdm_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  dpdm_pkg::dp_cmd_t                cmd_i,
  output dpdm_pkg::dp_sts_t                sts_o,
  output logic [dpdm_pkg::DUTY_W-1:0]      duty_percent_o,
  output logic [1:0]                       outcome_o,
  output logic [dpdm_pkg::READS_W-1:0]     high_reads_o,
  output logic [dpdm_pkg::READS_W-1:0]     low_reads_o
);
  import dpdm_pkg::*;

  localparam int unsigned NUM_W = COUNT_BITS + QUO_W;
  localparam int unsigned DEN_W = COUNT_BITS + 1;
  localparam int unsigned CMP_W = (COUNT_BITS > TIMEOUT_W) ? COUNT_BITS : TIMEOUT_W;
  localparam int unsigned DCF_W = (DEBOUNCE_BITS > DEB_CFG_W) ? DEBOUNCE_BITS : DEB_CFG_W;

  // Configuration registers.
  logic [DEBOUNCE_BITS-1:0] deb_q;
  logic [TIMEOUT_W-1:0]     tmo_q;
  logic [DCF_W-1:0]         deb_wr;

  // Wait counters and captured spans.
  logic [COUNT_BITS-1:0]    rc_q, rc_inc;
  logic [DEBOUNCE_BITS-1:0] mc_q;
  logic [COUNT_BITS-1:0]    high_q, low_q;
  logic                     match, accept, timeout, done;
  logic [COUNT_BITS-1:0]    val;

  // Divider registers.
  logic [NUM_W-1:0] rem_q, den_q;
  logic [DEN_W-1:0] den_sum;
  logic [QUO_W-1:0] quo_q;
  logic [2:0]       dcnt_q;
  logic             ge;

  // Result registers.
  logic [DUTY_W-1:0]  duty_q;
  outcome_e           outcome_q;
  logic [READS_W-1:0] hr_q, lr_q;

  // Keeps the low sixteen bits of a span count at any counter width.
  function automatic logic [READS_W-1:0] lo16(input logic [COUNT_BITS-1:0] x);
    logic [CMP_W-1:0] w;
    w = CMP_W'(x);
    return w[READS_W-1:0];
  endfunction

  // Configuration writes; the debounce register keeps its low bits only.
  assign deb_wr = DCF_W'(cfg_data_i[DEB_CFG_W-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q <= DEBOUNCE_BITS'(DEBOUNCE_RESET);
      tmo_q <= TIMEOUT_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_DEBOUNCE: deb_q <= deb_wr[DEBOUNCE_BITS-1:0];
        REG_TIMEOUT:  tmo_q <= cfg_data_i[TIMEOUT_W-1:0];
        default:      ;
      endcase
    end
  end

  // One sample: debounce match, saturating read count and timeout check.
  always_comb begin
    match   = (pin_level_i == cmd_i.expect_high);
    accept  = match && (mc_q >= deb_q);
    rc_inc  = (rc_q == '1) ? rc_q : rc_q + 1'b1;
    timeout = !accept && ((CMP_W'(rc_inc) >= CMP_W'(tmo_q)) || (rc_inc == '1));
    done    = accept || timeout;
    val     = accept ? rc_q : '0;
  end

  assign sts_o.done     = done;
  assign sts_o.val_gt0  = (val != '0);
  assign sts_o.val_gt1  = (val > COUNT_BITS'(1));
  assign sts_o.high_gt0 = (high_q != '0);
  assign sts_o.div_last = (dcnt_q == 3'd0);

  // Counters restart when a wait ends.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q <= '0;
      mc_q <= '0;
    end else if (cmd_i.sample_en) begin
      if (done) begin
        rc_q <= '0;
        mc_q <= '0;
      end else begin
        rc_q <= rc_inc;
        mc_q <= match ? mc_q + 1'b1 : '0;
      end
    end
  end

  // Span capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.high_cap) begin
      high_q <= val;
    end
    if (cmd_i.low_cap) begin
      low_q <= val;
    end
  end

  // Restoring divider: low*100 over low+high, one quotient bit per cycle.
  assign den_sum = DEN_W'(low_q) + DEN_W'(high_q);
  assign ge      = (rem_q >= den_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      rem_q  <= (NUM_W'(low_q) << 6) + (NUM_W'(low_q) << 5) + (NUM_W'(low_q) << 2);
      den_q  <= NUM_W'(den_sum) << (QUO_W - 1);
      quo_q  <= '0;
      dcnt_q <= 3'(QUO_W - 1);
    end else if (cmd_i.div_step) begin
      rem_q  <= ge ? rem_q - den_q : rem_q;
      den_q  <= den_q >> 1;
      quo_q  <= {quo_q[QUO_W-2:0], ge};
      dcnt_q <= dcnt_q - 3'd1;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      outcome_q <= cmd_i.res_sel;
      unique case (cmd_i.res_sel)
        OUT_STUCK_HIGH: begin
          duty_q <= '0;
          hr_q   <= '0;
          lr_q   <= '0;
        end
        OUT_STUCK_LOW: begin
          duty_q <= DUTY_FULL;
          hr_q   <= '0;
          lr_q   <= '0;
        end
        OUT_EDGE_LOST: begin
          duty_q <= DUTY_FULL;
          hr_q   <= lo16(high_q);
          lr_q   <= lo16(val);
        end
        OUT_MEASURED: begin
          duty_q <= {quo_q[QUO_W-2:0], ge};
          hr_q   <= lo16(high_q);
          lr_q   <= lo16(low_q);
        end
        default: ;
      endcase
    end
  end

  assign duty_percent_o = duty_q;
  assign outcome_o      = outcome_q;
  assign high_reads_o   = hr_q;
  assign low_reads_o    = lr_q;

endmodule

`default_nettype wire

// File: src/dpdm_ctrl.sv
`default_nettype none

module dpdm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  dpdm_pkg::dp_sts_t sts_i,
  output dpdm_pkg::dp_cmd_t cmd_o
);
  import dpdm_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        running, step_done;

  // Samples are taken in the four waits when the result register can make room.
  assign running = (state_q == ST_WAIT_LOW) || (state_q == ST_WAIT_HIGH) ||
                   (state_q == ST_HIGH_SPAN) || (state_q == ST_LOW_SPAN);
  assign in_ready_o = running && (!out_valid_q || out_ready_i);
  assign step_done  = in_valid_i && in_ready_o && sts_i.done;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_WAIT_LOW: begin
        if (step_done && sts_i.val_gt1) begin
          state_d = ST_WAIT_HIGH;
        end
      end
      ST_WAIT_HIGH: begin
        if (step_done) begin
          state_d = sts_i.val_gt0 ? ST_HIGH_SPAN : ST_WAIT_LOW;
        end
      end
      ST_HIGH_SPAN: begin
        if (step_done) begin
          state_d = ST_LOW_SPAN;
        end
      end
      ST_LOW_SPAN: begin
        if (step_done) begin
          state_d = (sts_i.val_gt0 && sts_i.high_gt0) ? ST_DIV_LOAD : ST_WAIT_LOW;
        end
      end
      ST_DIV_LOAD: state_d = ST_DIV_STEP;
      ST_DIV_STEP: begin
        if (sts_i.div_last) begin
          state_d = ST_WAIT_LOW;
        end
      end
      default: state_d = ST_WAIT_LOW;
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd_o             = '0;
    cmd_o.res_sel     = OUT_MEASURED;
    cmd_o.sample_en   = in_valid_i && in_ready_o;
    cmd_o.expect_high = (state_q == ST_WAIT_HIGH) || (state_q == ST_LOW_SPAN);
    unique case (state_q)
      ST_WAIT_LOW: begin
        if (step_done && !sts_i.val_gt1) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = OUT_STUCK_HIGH;
        end
      end
      ST_WAIT_HIGH: begin
        if (step_done && !sts_i.val_gt0) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = OUT_STUCK_LOW;
        end
      end
      ST_HIGH_SPAN: cmd_o.high_cap = step_done;
      ST_LOW_SPAN: begin
        if (step_done) begin
          if (sts_i.val_gt0 && sts_i.high_gt0) begin
            cmd_o.low_cap = 1'b1;
          end else begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_sel  = OUT_EDGE_LOST;
          end
        end
      end
      ST_DIV_LOAD: cmd_o.div_load = 1'b1;
      ST_DIV_STEP: begin
        cmd_o.div_step = 1'b1;
        cmd_o.res_load = sts_i.div_last;
        cmd_o.res_sel  = OUT_MEASURED;
      end
      default: ;
    endcase
  end

  // Result valid flag: set when a result is loaded, cleared by its transfer.
  assign out_valid_d = cmd_o.res_load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_WAIT_LOW;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  // A new result never overwrites one that has not been transferred.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_load |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a pending result");

  // No sample is taken while the divider runs.
  a_div_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV_LOAD || state_q == ST_DIV_STEP) |-> !in_ready_o)
    else $error("input ready during division");

  // Loading the divider is always followed by its steps.
  a_load_then_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV_LOAD) |=> (state_q == ST_DIV_STEP))
    else $error("divider load not followed by a step");

  // The last divider step produces a valid result.
  a_div_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV_STEP && sts_i.div_last) |=> (out_valid_q && state_q == ST_WAIT_LOW))
    else $error("division finished without a result");
`endif

endmodule

`default_nettype wire

// File: src/debounced_pwm_duty_meter.sv
`default_nettype none

// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_ready_o   pin_level_i
// out       output     out_valid_o / out_ready_i duty_percent_o, outcome_o,
//                                                high_reads_o, low_reads_o
// cfg       input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One pin sample is taken per cycle while a measurement waits for its levels and no pending result stalls the input.
// When both spans are nonzero the duty divider runs (one load and seven restoring
// steps, one quotient bit each) and takes no samples meanwhile.
// After reset all registers are ready at once; there is no clearing pass.
// A pending result stalls the sample input only while out_ready_i is low.
// The configuration port accepts a write in every cycle.

module debounced_pwm_duty_meter #(
  parameter int unsigned COUNT_BITS    = dpdm_pkg::COUNT_BITS_DEF,
  parameter int unsigned DEBOUNCE_BITS = dpdm_pkg::DEBOUNCE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            pin_level_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [dpdm_pkg::DUTY_W-1:0]     duty_percent_o,
  output logic [1:0]                      outcome_o,
  output logic [dpdm_pkg::READS_W-1:0]    high_reads_o,
  output logic [dpdm_pkg::READS_W-1:0]    low_reads_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [dpdm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [dpdm_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import dpdm_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Configuration writes are always accepted.
  assign cfg_ready_o = 1'b1;

  // Measurement sequencer.
  dpdm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Counters, divider and result register.
  dpdm_dp #(
    .COUNT_BITS    (COUNT_BITS),
    .DEBOUNCE_BITS (DEBOUNCE_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pin_level_i    (pin_level_i),
    .cfg_valid_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .duty_percent_o (duty_percent_o),
    .outcome_o      (outcome_o),
    .high_reads_o   (high_reads_o),
    .low_reads_o    (low_reads_o)
  );

endmodule

`default_nettype wire
